@@ hdl/uct_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// uct_pkg
// Types and constants shared by the URL component tagger.
// ---------------------------------------------------------------------------
package uct_pkg;

  typedef enum logic [2:0] {
    PH_LEAD   = 3'd0,
    PH_HOST   = 3'd1,
    PH_PORT   = 3'd2,
    PH_PATH   = 3'd3,
    PH_SEARCH = 3'd4,
    PH_HASH   = 3'd5
  } phase_t;

  localparam logic [1:0] HELD_NONE  = 2'd0;
  localparam logic [1:0] HELD_COLON = 2'd1;
  localparam logic [1:0] HELD_SLASH = 2'd2;

  localparam logic [2:0] TAG_LEAD  = 3'd0;
  localparam logic [2:0] TAG_DELIM = 3'd7;

  localparam logic [1:0] RES_NONE  = 2'd0;
  localparam logic [1:0] RES_PROTO = 2'd1;
  localparam logic [1:0] RES_HOST  = 2'd2;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [15:0] PORT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [7:0]  byte_val;
    logic [2:0]  tag;
    logic [1:0]  res;
    logic [15:0] port;
    logic        sat;
    logic        done;
    logic        last;
  } result_t;

endpackage
`default_nettype wire

@@ hdl/url_component_tagger.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// url_component_tagger
// Tags each URL byte as lead, host, port, path, search, hash or delimiter,
// resolves the lead to protocol or host, and sums the decimal port value.
// ---------------------------------------------------------------------------
// One input beat is taken per cycle while in_ready is high and yields zero
// to three result beats. The results of a beat are computed in the cycle it
// is accepted and land in a three-entry result queue that drains one beat
// per cycle while out_ready is high; a new input beat is taken once the
// queue holds at most one beat that leaves in the same cycle. Bytes that
// produce one result each therefore stream at one byte per clock while
// out_ready stays high; a byte that flushes a held ":" or ":/" stalls input
// until its extra beats drain. The first result follows in the next cycle.
// ---------------------------------------------------------------------------
module url_component_tagger
  import uct_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  input  wire logic        last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic [2:0]       part_tag,
  output logic [1:0]       lead_resolved,
  output logic [15:0]      port_value,
  output logic             port_overflow,
  output logic             url_done,
  output logic             run_last
);

  phase_t      phase, phase_next;
  logic [1:0]  held_count, held_next;
  logic [15:0] port_accum, port_next;
  logic        port_stopped, stopped_next;
  logic        port_sat, sat_next;

  result_t     rq [3];
  logic [1:0]  rq_cnt;

  logic        in_fire, out_fire;
  logic        is_nl, end_b, is_slash, is_digit;

  phase_t      tk_phase, dl_phase;
  logic        tk_lead, do_take, tk_valid, is_delim;
  result_t     tk_ent;
  result_t     pre [3];
  logic [1:0]  pre_n, res_n;
  result_t     ent [3];
  logic [19:0] port_mul;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign in_ready = (rq_cnt == 2'd0) || (rq_cnt == 2'd1 && out_ready);

  assign is_nl    = (in_byte == CH_NL);
  assign end_b    = last_byte || is_nl;
  assign is_slash = (in_byte == CH_SLASH);
  assign is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
  assign port_mul = {1'b0, port_accum, 3'b000} + {3'b000, port_accum, 1'b0}
                  + {16'd0, in_byte[3:0]};

  function automatic result_t mk(input logic [7:0] b, input logic [2:0] t,
                                 input logic [1:0] r, input logic [15:0] p,
                                 input logic s);
    result_t e;
    e.byte_val = b;
    e.tag      = t;
    e.res      = r;
    e.port     = p;
    e.sat      = s;
    e.done     = 1'b0;
    e.last     = 1'b0;
    return e;
  endfunction

  // held-byte flush ahead of the current byte
  always_comb begin
    tk_phase  = phase;
    tk_lead   = (phase == PH_LEAD);
    do_take   = 1'b1;
    pre_n     = 2'd0;
    held_next = HELD_NONE;
    for (int i = 0; i < 3; i++) begin
      pre[i] = '0;
    end
    if (phase == PH_LEAD && held_count == HELD_COLON) begin
      if (is_slash && !end_b) begin
        do_take   = 1'b0;
        held_next = HELD_SLASH;
      end else begin
        pre[0]   = mk(CH_COLON, TAG_DELIM, RES_HOST, port_accum, port_sat);
        pre_n    = 2'd1;
        tk_phase = PH_PORT;
        tk_lead  = 1'b0;
      end
    end else if (phase == PH_LEAD && held_count == HELD_SLASH) begin
      pre[1] = mk(CH_SLASH, TAG_DELIM, RES_NONE, port_accum, port_sat);
      if (is_slash) begin
        pre[0]   = mk(CH_COLON, TAG_DELIM, RES_PROTO, port_accum, port_sat);
        pre[2]   = mk(CH_SLASH, TAG_DELIM, RES_NONE, port_accum, port_sat);
        pre_n    = 2'd3;
        do_take  = 1'b0;
        tk_phase = PH_HOST;
      end else begin
        pre[0]   = mk(CH_COLON, TAG_DELIM, RES_HOST, port_accum, port_sat);
        pre_n    = 2'd2;
        tk_phase = PH_PATH;
        tk_lead  = 1'b0;
      end
    end
  end

  // current byte
  always_comb begin
    is_delim = 1'b1;
    dl_phase = tk_phase;
    if (in_byte == CH_HASH && tk_phase < PH_HASH) begin
      dl_phase = PH_HASH;
    end else if (in_byte == CH_QUEST && tk_phase < PH_SEARCH) begin
      dl_phase = PH_SEARCH;
    end else if (is_slash && tk_phase < PH_PATH) begin
      dl_phase = PH_PATH;
    end else if (in_byte == CH_COLON && tk_phase < PH_PORT) begin
      dl_phase = PH_PORT;
    end else begin
      is_delim = 1'b0;
    end
  end

  always_comb begin
    phase_next   = tk_phase;
    port_next    = port_accum;
    stopped_next = port_stopped;
    sat_next     = port_sat;
    tk_valid     = 1'b0;
    tk_ent       = '0;
    if (do_take) begin
      if (is_nl) begin
        tk_valid = 1'b1;
        tk_ent   = mk(in_byte, TAG_DELIM, tk_lead ? RES_HOST : RES_NONE,
                      port_accum, port_sat);
      end else if (tk_lead && in_byte == CH_COLON && !end_b) begin
        tk_valid = 1'b0;
      end else if (is_delim) begin
        tk_valid   = 1'b1;
        phase_next = dl_phase;
        tk_ent     = mk(in_byte, TAG_DELIM, tk_lead ? RES_HOST : RES_NONE,
                        port_accum, port_sat);
      end else begin
        if (tk_phase == PH_PORT) begin
          if (is_digit && !port_stopped) begin
            if (port_mul[19:16] != 4'd0) begin
              port_next = PORT_MAX;
              sat_next  = 1'b1;
            end else begin
              port_next = port_mul[15:0];
            end
          end else begin
            stopped_next = 1'b1;
          end
        end
        tk_valid = 1'b1;
        tk_ent   = mk(in_byte, tk_lead ? TAG_LEAD : (3'(tk_phase) + 3'd1),
                      (tk_lead && end_b) ? RES_HOST : RES_NONE,
                      port_next, sat_next);
      end
    end
  end

  always_comb begin
    res_n = pre_n + {1'b0, tk_valid};
    for (int k = 0; k < 3; k++) begin
      if (2'(k) < pre_n) begin
        ent[k] = pre[k];
      end else begin
        ent[k] = tk_ent;
      end
      if (res_n != 2'd0 && 2'(k) == res_n - 2'd1) begin
        ent[k].last = 1'b1;
        ent[k].done = end_b;
      end
    end
  end

  // parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_LEAD;
      held_count   <= HELD_NONE;
      port_accum   <= '0;
      port_stopped <= 1'b0;
      port_sat     <= 1'b0;
    end else if (in_fire) begin
      if (end_b) begin
        phase        <= PH_LEAD;
        held_count   <= HELD_NONE;
        port_accum   <= '0;
        port_stopped <= 1'b0;
        port_sat     <= 1'b0;
      end else begin
        phase        <= phase_next;
        held_count   <= (tk_lead && do_take && in_byte == CH_COLON)
                        ? HELD_COLON : held_next;
        port_accum   <= port_next;
        port_stopped <= stopped_next;
        port_sat     <= sat_next;
      end
    end
  end

  // result queue
  always_ff @(posedge clk) begin
    if (rst) begin
      rq_cnt <= 2'd0;
    end else if (in_fire) begin
      rq_cnt <= res_n;
    end else if (out_fire) begin
      rq_cnt <= rq_cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rq[0] <= ent[0];
      rq[1] <= ent[1];
      rq[2] <= ent[2];
    end else if (out_fire) begin
      rq[0] <= rq[1];
      rq[1] <= rq[2];
    end
  end

  assign out_valid     = (rq_cnt != 2'd0);
  assign out_byte      = rq[0].byte_val;
  assign part_tag      = rq[0].tag;
  assign lead_resolved = rq[0].res;
  assign port_value    = rq[0].port;
  assign port_overflow = rq[0].sat;
  assign url_done      = rq[0].done;
  assign run_last      = rq[0].last;

endmodule
`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Bench for url_component_tagger. Drives URL bytes over a valid/ready beat
// interface with random gaps and output stalls. Each accepted byte runs
// through a bench-side tagger that queues the expected tagged beats, and
// every output beat is compared field by field against that queue.
// ---------------------------------------------------------------------------
module tb_top;
  import uct_pkg::*;

  localparam int IDLE_LIMIT     = 2000;
  localparam int DRAIN_LIMIT    = 1000;
  localparam int RX_HOLD_CYCLES = 80;

  logic        clk;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte   = 8'h00;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic [2:0]  part_tag;
  logic [1:0]  lead_resolved;
  logic [15:0] port_value;
  logic        port_overflow;
  logic        url_done;
  logic        run_last;

  url_component_tagger dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte       (in_byte),
    .last_byte     (last_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .part_tag      (part_tag),
    .lead_resolved (lead_resolved),
    .port_value    (port_value),
    .port_overflow (port_overflow),
    .url_done      (url_done),
    .run_last      (run_last)
  );

  // bench-side tagger state
  phase_t      url_phase   = PH_LEAD;
  logic [1:0]  held_state  = HELD_NONE;
  logic [15:0] port_total  = 16'd0;
  bit          port_halted = 1'b0;
  bit          port_capped = 1'b0;
  int          beats_this_byte;
  result_t     expected_tags[$];
  result_t     want;

  int errors      = 0;
  int bytes_sent  = 0;
  int idle_cycles = 0;
  int rx_wait     = 0;
  int wait_cnt;
  bit tx_calm     = 1'b0;
  bit rx_calm     = 1'b0;
  bit rx_hold_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ------------------------------------------------------------------------
  // Expected-tag computation
  // ------------------------------------------------------------------------
  function automatic void emit_tag(input logic [7:0] b, input logic [2:0] tag,
                                   input logic [1:0] res);
    result_t r;
    r.byte_val = b;
    r.tag      = tag;
    r.res      = res;
    r.port     = port_total;
    r.sat      = port_capped;
    r.done     = 1'b0;
    r.last     = 1'b0;
    expected_tags.push_back(r);
    beats_this_byte++;
  endfunction

  task automatic classify_byte(input logic [7:0] b, input bit fin, input bit nl);
    bit         lead;
    bit         delim;
    phase_t     nxt;
    logic [19:0] v;
    lead  = (url_phase == PH_LEAD);
    nxt   = url_phase;
    delim = 1'b1;
    if (nl) begin
      emit_tag(b, TAG_DELIM, lead ? RES_HOST : RES_NONE);
    end else if (lead && b == CH_COLON && !fin) begin
      held_state = HELD_COLON;
    end else begin
      if (b == CH_HASH && url_phase < PH_HASH) nxt = PH_HASH;
      else if (b == CH_QUEST && url_phase < PH_SEARCH) nxt = PH_SEARCH;
      else if (b == CH_SLASH && url_phase < PH_PATH) nxt = PH_PATH;
      else if (b == CH_COLON && url_phase < PH_PORT) nxt = PH_PORT;
      else delim = 1'b0;
      if (delim) begin
        url_phase = nxt;
        emit_tag(b, TAG_DELIM, lead ? RES_HOST : RES_NONE);
      end else begin
        if (url_phase == PH_PORT) begin
          if (b >= CH_ZERO && b <= CH_NINE && !port_halted) begin
            v = 20'(port_total) * 20'd10 + 20'(b - CH_ZERO);
            if (v > 20'(PORT_MAX)) begin
              port_total  = PORT_MAX;
              port_capped = 1'b1;
            end else begin
              port_total = v[15:0];
            end
          end else begin
            port_halted = 1'b1;
          end
        end
        // content tags sit one above the phase code
        emit_tag(b, lead ? TAG_LEAD : 3'(url_phase) + 3'd1,
                 (lead && fin) ? RES_HOST : RES_NONE);
      end
    end
  endtask

  task automatic tag_byte(input logic [7:0] b, input logic lb);
    bit      nl;
    bit      fin;
    result_t r;
    nl  = (b == CH_NL);
    fin = lb || nl;
    beats_this_byte = 0;
    if (url_phase == PH_LEAD && held_state == HELD_COLON) begin
      if (b == CH_SLASH && !fin) begin
        held_state = HELD_SLASH;
      end else begin
        held_state = HELD_NONE;
        url_phase  = PH_PORT;
        emit_tag(CH_COLON, TAG_DELIM, RES_HOST);
        classify_byte(b, fin, nl);
      end
    end else if (url_phase == PH_LEAD && held_state == HELD_SLASH) begin
      held_state = HELD_NONE;
      if (b == CH_SLASH) begin
        emit_tag(CH_COLON, TAG_DELIM, RES_PROTO);
        emit_tag(CH_SLASH, TAG_DELIM, RES_NONE);
        emit_tag(CH_SLASH, TAG_DELIM, RES_NONE);
        url_phase = PH_HOST;
      end else begin
        emit_tag(CH_COLON, TAG_DELIM, RES_HOST);
        emit_tag(CH_SLASH, TAG_DELIM, RES_NONE);
        url_phase = PH_PATH;
        classify_byte(b, fin, nl);
      end
    end else begin
      held_state = HELD_NONE;
      classify_byte(b, fin, nl);
    end
    if (beats_this_byte > 0) begin
      r      = expected_tags.pop_back();
      r.last = 1'b1;
      r.done = fin;
      expected_tags.push_back(r);
    end
    if (fin) begin
      url_phase   = PH_LEAD;
      held_state  = HELD_NONE;
      port_total  = 16'd0;
      port_halted = 1'b0;
      port_capped = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) tag_byte(in_byte, last_byte);
  end

  // ------------------------------------------------------------------------
  // Output check
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_tags.size() == 0) begin
        $error("unexpected result beat: out_byte %h part_tag %0d", out_byte, part_tag);
        errors++;
      end else begin
        want = expected_tags.pop_front();
        if (out_byte !== want.byte_val) begin
          $error("out_byte: expected %h, got %h", want.byte_val, out_byte);
          errors++;
        end
        if (part_tag !== want.tag) begin
          $error("part_tag: expected %0d, got %0d", want.tag, part_tag);
          errors++;
        end
        if (lead_resolved !== want.res) begin
          $error("lead_resolved: expected %0d, got %0d", want.res, lead_resolved);
          errors++;
        end
        if (port_value !== want.port) begin
          $error("port_value: expected %0d, got %0d", want.port, port_value);
          errors++;
        end
        if (port_overflow !== want.sat) begin
          $error("port_overflow: expected %0d, got %0d", want.sat, port_overflow);
          errors++;
        end
        if (url_done !== want.done) begin
          $error("url_done: expected %0d, got %0d", want.done, url_done);
          errors++;
        end
        if (run_last !== want.last) begin
          $error("run_last: expected %0d, got %0d", want.last, run_last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ------------------------------------------------------------------------
  // Random gaps, sender and receiver
  // ------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        rx_wait     = RX_HOLD_CYCLES;
      end
      if (rx_wait > 0) begin
        out_ready <= 1'b0;
        rx_wait--;
      end else begin
        out_ready <= 1'b1;
        if (!rx_calm) rx_wait = pick_gap();
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic lb);
    int gap;
    gap = tx_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_byte   <= b;
    last_byte <= lb;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_text(input string s, input bit lb_end);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i], lb_end && (i == s.len() - 1));
  endtask

  task automatic wait_for_tags();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_tags.size() != 0);
  endtask

  function automatic logic [7:0] word_char();
    case ($urandom_range(0, 9))
      0:       return CH_ZERO + 8'($urandom_range(0, 9));
      1:       return 8'h2E;                                // '.'
      2:       return 8'h41 + 8'($urandom_range(0, 25));    // upper case
      default: return 8'h61 + 8'($urandom_range(0, 25));    // lower case
    endcase
  endfunction

  function automatic logic [7:0] body_char();
    case ($urandom_range(0, 11))
      0:       return CH_COLON;
      1:       return CH_SLASH;
      2:       return CH_QUEST;
      3:       return CH_HASH;
      default: return word_char();
    endcase
  endfunction

  function automatic logic [7:0] noise_char();
    case ($urandom_range(0, 9))
      0:       return CH_COLON;
      1:       return CH_SLASH;
      2:       return CH_QUEST;
      3:       return CH_HASH;
      4:       return CH_NL;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // scheme / host / port / path / search / hash, each optional; sometimes
  // cut short so the URL ends inside a held colon or slash
  task automatic send_random_url();
    logic [7:0] s[$];
    int         k;
    int         n;
    int         i;
    bit         lb_final;
    s = {};
    k = $urandom_range(0, 99);
    if (k < 45) begin
      repeat ($urandom_range(1, 4)) s.push_back(word_char());
      s.push_back(CH_COLON);
      s.push_back(CH_SLASH);
      s.push_back(CH_SLASH);
    end else if (k < 55) begin
      repeat ($urandom_range(1, 3)) s.push_back(word_char());
      s.push_back(CH_COLON);
      s.push_back(CH_SLASH);
      s.push_back(word_char());
    end
    repeat ($urandom_range(0, 5)) s.push_back(word_char());
    if ($urandom_range(0, 99) < 40) begin
      s.push_back(CH_COLON);
      n = ($urandom_range(0, 99) < 15) ? $urandom_range(6, 8) : $urandom_range(0, 5);
      repeat (n) s.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      if ($urandom_range(0, 99) < 20) begin
        s.push_back(word_char());
        s.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      end
    end
    repeat ($urandom_range(0, 2)) begin
      s.push_back(CH_SLASH);
      repeat ($urandom_range(0, 4)) s.push_back(body_char());
    end
    if ($urandom_range(0, 99) < 30) begin
      s.push_back(CH_QUEST);
      repeat ($urandom_range(0, 4)) s.push_back(body_char());
    end
    if ($urandom_range(0, 99) < 30) begin
      s.push_back(CH_HASH);
      repeat ($urandom_range(0, 4)) s.push_back(body_char());
    end
    if (s.size() == 0) s.push_back(word_char());
    if ($urandom_range(0, 99) < 15) begin
      n = $urandom_range(1, s.size());
      while (s.size() > n) s.delete(s.size() - 1);
    end
    k = $urandom_range(0, 99);
    if (k < 55) begin
      lb_final = 1'b1;
    end else begin
      s.push_back(CH_NL);
      lb_final = (k >= 90);
    end
    for (i = 0; i < s.size(); i++) send_byte(s[i], lb_final && (i == s.size() - 1));
  endtask

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------
  task automatic test_component_tags();
    send_text("a://b:9/c?d#e", 1'b1);
    send_text("h:/x", 1'b1);
    send_text("z:", 1'b1);
    send_text("q", 1'b1);
    send_text("\n", 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  // long output stall with the sender streaming; input must back up
  task automatic test_output_stall();
    tx_calm     = 1'b1;
    rx_hold_req = 1'b1;
    send_text("k://h:99999z7/p:/q?r#t#\n", 1'b0);
    send_text("w:/v", 1'b1);
    tx_calm = 1'b0;
  endtask

  task automatic test_back_to_back();
    int stop_at;
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    stop_at = bytes_sent + 25;
    while (bytes_sent < stop_at) send_random_url();
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  task automatic test_random_urls(input int count);
    int stop_at;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 99) < 15) begin
        repeat ($urandom_range(1, 4)) send_byte(noise_char(), $urandom_range(0, 3) == 0);
      end else begin
        send_random_url();
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_component_tags();
    wait_for_tags();
    test_output_stall();
    wait_for_tags();
    test_back_to_back();
    test_random_urls(75);
    wait_for_tags();
    test_random_urls(75);
    in_valid <= 1'b0;
    wait_cnt = 0;
    do begin
      @(posedge clk);
      wait_cnt++;
    end while (expected_tags.size() != 0 && wait_cnt < DRAIN_LIMIT);
    repeat (8) @(posedge clk);
    if (expected_tags.size() != 0) begin
      $error("%0d expected result beats never arrived", expected_tags.size());
      errors++;
    end
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ url_component_tagger.f @@
hdl/uct_pkg.sv
hdl/url_component_tagger.sv
bench/tb_top.sv
